FILE: rtl/core/ser_pkg.sv
// Shared constants and codes for the silence endpoint recorder.
package ser_pkg;

    // Parameter defaults.
    localparam int ADDR_BITS_DEF   = 20;
    localparam int ENERGY_BITS_DEF = 40;

    // Fixed field widths.
    localparam int CNT_W   = 21;
    localparam int MS_W    = 20;
    localparam int TIME_W  = 32;
    localparam int THR_W   = 31;
    localparam int SAMP_W  = 16;
    localparam int CMD_W   = 2;
    localparam int CAUSE_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    // Threshold accumulator: threshold times up to 2^21-1 stored samples.
    localparam int THR_ACC_W = THR_W + CNT_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BLOCK  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POLL   = 2'd3;

    // Stop causes.
    localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_MAXTIME = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_FULL    = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_SILENCE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY   = 3'd4;

    // Configuration reset values.
    localparam logic [CNT_W-1:0] CAPACITY_RST = 21'd160000;
    localparam logic [MS_W-1:0]  MIN_MS_RST   = 20'd1000;
    localparam logic [MS_W-1:0]  MAX_MS_RST   = 20'd10000;
    localparam logic [MS_W-1:0]  HOLD_MS_RST  = 20'd1500;
    localparam logic [THR_W-1:0] ENERGY_RST   = 31'd1048576;

endpackage

FILE: rtl/core/silence_endpoint_recorder.sv
// Top level of the energy-based end-of-utterance recorder.

// Each accepted transaction (start, sample, block end or empty poll) yields exactly one
// result transaction, in the cycle after acceptance, and a new transaction is taken every
// cycle while the result register is empty or being drained. A single result register
// separates the two channels. The block energy test compares the saturating sum of
// squares against the threshold times the number of samples stored in the block, a
// product formed at block end from the current threshold. Samples are stored at
// write_index only while recording and while room remains; a full buffer is reported at
// the following block end.
module silence_endpoint_recorder #(
    parameter int ADDR_BITS   = ser_pkg::ADDR_BITS_DEF,
    parameter int ENERGY_BITS = ser_pkg::ENERGY_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration port
    input  logic                            cfg_wr_en,
    input  logic [ser_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ser_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // Input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ser_pkg::CMD_W-1:0]       s_cmd,
    input  logic signed [ser_pkg::SAMP_W-1:0] s_sample_value,
    input  logic [ser_pkg::TIME_W-1:0]      s_now_ms,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_recording,
    output logic                            m_write_enable,
    output logic [ADDR_BITS-1:0]            m_write_index,
    output logic signed [ser_pkg::SAMP_W-1:0] m_write_data,
    output logic                            m_finished,
    output logic [ser_pkg::CAUSE_W-1:0]     m_stop_cause,
    output logic [ser_pkg::CNT_W-1:0]       m_recorded_samples
);
    import ser_pkg::*;

    localparam int LIM_W = (ADDR_BITS + 1 > CNT_W) ? ADDR_BITS + 1 : CNT_W;

    // Configuration registers.
    logic [CNT_W-1:0] capacity_reg;
    logic [MS_W-1:0]  min_ms_reg;
    logic [MS_W-1:0]  max_ms_reg;
    logic [MS_W-1:0]  hold_ms_reg;
    logic [THR_W-1:0] energy_thr_reg;

    // Recorder state.
    logic                   active_reg, active_next;
    logic [TIME_W-1:0]      start_time_reg, start_time_next;
    logic                   sil_pend_reg, sil_pend_next;
    logic [TIME_W-1:0]      sil_start_reg, sil_start_next;
    logic [CNT_W-1:0]       stored_cnt_reg, stored_cnt_next;
    logic [ENERGY_BITS-1:0] blk_energy_reg, blk_energy_next;
    logic [CNT_W-1:0]       blk_cnt_reg, blk_cnt_next;
    logic                   blk_any_st_reg, blk_any_st_next;
    logic                   blk_any_rx_reg, blk_any_rx_next;

    // Result register.
    logic                   m_valid_reg, m_valid_next;
    logic                   recording_reg, recording_next;
    logic                   wen_reg, wen_next;
    logic [ADDR_BITS-1:0]   widx_reg, widx_next;
    logic [SAMP_W-1:0]      wdata_reg, wdata_next;
    logic                   fin_reg, fin_next;
    logic [CAUSE_W-1:0]     cause_reg, cause_next;
    logic [CNT_W-1:0]       rec_cnt_reg, rec_cnt_next;

    logic                   accept;
    logic [LIM_W-1:0]       room_limit;
    logic                   has_room;
    logic [TIME_W-1:0]      elapsed;
    logic [TIME_W-1:0]      sil_elapsed;
    logic                   over_max;
    logic                   silent;
    logic [THR_ACC_W-1:0]   thr_prod;
    logic [31:0]            sample_sq;
    logic [ENERGY_BITS:0]   energy_sum;
    logic [CAUSE_W-1:0]     cause;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Buffer room, bounded by the address space.
    always_comb begin
        if (LIM_W'(capacity_reg) < (LIM_W'(1) << ADDR_BITS)) begin
            room_limit = LIM_W'(capacity_reg);
        end else begin
            room_limit = LIM_W'(1) << ADDR_BITS;
        end
    end
    assign has_room = LIM_W'(stored_cnt_reg) < room_limit;

    // Timing and energy terms shared by the command paths.
    assign elapsed    = s_now_ms - start_time_reg;
    assign over_max   = elapsed >= TIME_W'(max_ms_reg);
    assign sample_sq  = 32'(s_sample_value * s_sample_value);
    assign energy_sum = (ENERGY_BITS+1)'(blk_energy_reg) + (ENERGY_BITS+1)'(sample_sq);
    assign thr_prod   = THR_ACC_W'(energy_thr_reg) * THR_ACC_W'(blk_cnt_reg);

    // A block with no stored samples is silent whenever the threshold is nonzero.
    always_comb begin
        if (blk_any_st_reg) begin
            silent = THR_ACC_W'(blk_energy_reg) < thr_prod;
        end else begin
            silent = energy_thr_reg != '0;
        end
    end

    // Next state and result for the accepted transaction.
    always_comb begin
        active_next     = active_reg;
        start_time_next = start_time_reg;
        sil_pend_next   = sil_pend_reg;
        sil_start_next  = sil_start_reg;
        stored_cnt_next = stored_cnt_reg;
        blk_energy_next = blk_energy_reg;
        blk_cnt_next    = blk_cnt_reg;
        blk_any_st_next = blk_any_st_reg;
        blk_any_rx_next = blk_any_rx_reg;
        wen_next        = 1'b0;
        widx_next       = '0;
        wdata_next      = '0;
        cause           = CAUSE_NONE;
        sil_elapsed     = '0;

        if (s_cmd == CMD_START) begin
            active_next     = 1'b1;
            start_time_next = s_now_ms;
            sil_pend_next   = 1'b0;
            sil_start_next  = '0;
            stored_cnt_next = '0;
            blk_energy_next = '0;
            blk_cnt_next    = '0;
            blk_any_st_next = 1'b0;
            blk_any_rx_next = 1'b0;
        end else if (active_reg && s_cmd == CMD_SAMPLE) begin
            blk_any_rx_next = 1'b1;
            if (has_room) begin
                wen_next        = 1'b1;
                widx_next       = ADDR_BITS'(stored_cnt_reg);
                wdata_next      = s_sample_value;
                stored_cnt_next = stored_cnt_reg + 1'b1;
                blk_any_st_next = 1'b1;
                blk_cnt_next    = blk_cnt_reg + 1'b1;
                if (energy_sum[ENERGY_BITS]) begin
                    blk_energy_next = '1;
                end else begin
                    blk_energy_next = energy_sum[ENERGY_BITS-1:0];
                end
            end
        end else if (active_reg && s_cmd == CMD_BLOCK && blk_any_rx_reg) begin
            // Block end: update the silence timer, then pick the stop cause.
            if (elapsed >= TIME_W'(min_ms_reg) && silent) begin
                if (!sil_pend_reg) begin
                    sil_pend_next  = 1'b1;
                    sil_start_next = s_now_ms;
                end
            end else begin
                sil_pend_next = 1'b0;
            end
            sil_elapsed = s_now_ms - sil_start_next;
            if (over_max) begin
                cause = CAUSE_MAXTIME;
            end else if (!has_room) begin
                cause = CAUSE_FULL;
            end else if (sil_pend_next && sil_elapsed >= TIME_W'(hold_ms_reg)) begin
                cause = CAUSE_SILENCE;
            end
            blk_energy_next = '0;
            blk_cnt_next    = '0;
            blk_any_st_next = 1'b0;
            blk_any_rx_next = 1'b0;
        end else if (active_reg && (s_cmd == CMD_POLL || s_cmd == CMD_BLOCK)) begin
            // Empty poll, or a block end with nothing received.
            if (over_max) begin
                cause = CAUSE_MAXTIME;
            end
        end

        if (cause != CAUSE_NONE) begin
            active_next = 1'b0;
        end
        fin_next       = cause != CAUSE_NONE;
        cause_next     = cause;
        recording_next = active_next;
        rec_cnt_next   = stored_cnt_next;
    end

    // Result valid: set on acceptance, cleared once taken.
    always_comb begin
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= CAPACITY_RST;
            min_ms_reg     <= MIN_MS_RST;
            max_ms_reg     <= MAX_MS_RST;
            hold_ms_reg    <= HOLD_MS_RST;
            energy_thr_reg <= ENERGY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_CAPACITY: capacity_reg   <= cfg_wdata[CNT_W-1:0];
                REG_MIN_MS:   min_ms_reg     <= cfg_wdata[MS_W-1:0];
                REG_MAX_MS:   max_ms_reg     <= cfg_wdata[MS_W-1:0];
                REG_HOLD_MS:  hold_ms_reg    <= cfg_wdata[MS_W-1:0];
                REG_ENERGY:   energy_thr_reg <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Recorder state and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= 1'b0;
            start_time_reg <= '0;
            sil_pend_reg   <= 1'b0;
            sil_start_reg  <= '0;
            stored_cnt_reg <= '0;
            blk_energy_reg <= '0;
            blk_cnt_reg    <= '0;
            blk_any_st_reg <= 1'b0;
            blk_any_rx_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                active_reg     <= active_next;
                start_time_reg <= start_time_next;
                sil_pend_reg   <= sil_pend_next;
                sil_start_reg  <= sil_start_next;
                stored_cnt_reg <= stored_cnt_next;
                blk_energy_reg <= blk_energy_next;
                blk_cnt_reg    <= blk_cnt_next;
                blk_any_st_reg <= blk_any_st_next;
                blk_any_rx_reg <= blk_any_rx_next;
            end
        end
    end

    // Result payload, loaded on acceptance.
    always_ff @(posedge aclk) begin
        if (accept) begin
            recording_reg <= recording_next;
            wen_reg       <= wen_next;
            widx_reg      <= widx_next;
            wdata_reg     <= wdata_next;
            fin_reg       <= fin_next;
            cause_reg     <= cause_next;
            rec_cnt_reg   <= rec_cnt_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_recording        = recording_reg;
    assign m_write_enable     = wen_reg;
    assign m_write_index      = widx_reg;
    assign m_write_data       = wdata_reg;
    assign m_finished         = fin_reg;
    assign m_stop_cause       = cause_reg;
    assign m_recorded_samples = rec_cnt_reg;

    // A finishing result names a cause and reports recording stopped.
    a_fin_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_finished) |-> (m_stop_cause != CAUSE_NONE && !m_recording))
        else $error("finished result without cause or still recording");

    // A stored sample only happens while recording continues.
    a_write_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_enable) |-> (m_recording && !m_finished))
        else $error("sample stored outside recording");

    // The stored sample index is one below the updated sample count.
    a_write_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_write_enable) |->
            (m_write_index == ADDR_BITS'(m_recorded_samples - 1'b1)))
        else $error("write index does not match sample count");

    // A start transaction yields a fresh recording with no samples.
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_cmd == CMD_START) |=>
            (m_valid && m_recording && m_recorded_samples == '0 && !m_write_enable))
        else $error("start did not open a fresh recording");

endmodule
